// ----- src/mrts_pkg.sv -----
// types and constants shared by the memory region table sanitizer
package mrts_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_LOW_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_CAP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_USABLE_CAP = 2'd2;

  localparam logic [31:0] LOW_LIMIT_RST = 32'd1048576;
  localparam logic [47:0] UPPER_CAP_RST = 48'h0001_0000_0000;
  localparam logic [31:0] USABLE_CAP_RST = 32'd4194304;

  localparam logic [31:0] SEAL_MAGIC = 32'h4D4D_4150;
  localparam int unsigned KbShift = 10;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_BAD_KIND = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_MALFORMED = 3'd4;

  localparam logic [2:0] KIND_AVAIL = 3'd0;
  localparam logic [2:0] KIND_RSVD = 3'd1;
  localparam logic [2:0] KIND_INVALID = 3'd5;
  localparam logic [31:0] RAW_KIND_MAX = 32'd5;

  typedef struct packed {
    logic        op;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] raw_kind;
  } mrts_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        stored;
    logic        usable_flag;
    logic [63:0] kept_base;
    logic [63:0] kept_length;
    logic [2:0]  kind_code;
    logic [5:0]  entry_count;
    logic [31:0] usable_total_kb;
    logic [31:0] map_seal;
  } mrts_out_t;

  // outcome of sanitizing one offered region
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind;
    logic        usable;
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] end_addr;
  } mrts_san_t;

endpackage

// ----- src/mrts_ram.sv -----
// generic single-port-write, registered-read ram
module mrts_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mrts_sanitize.sv -----
// multi-cycle sanitizer: kind decode, malformed check, clip, cap trim, page align
module mrts_sanitize import mrts_pkg::*; #(
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] base_i,
  input  logic [63:0] len_i,
  input  logic [31:0] raw_kind_i,
  input  logic [31:0] low_i,
  input  logic [47:0] cap_i,
  output logic        done_o,
  output mrts_san_t   res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_CLIP, S_CAP, S_ALIGN, S_TRIM
  } state_e;

  localparam logic [63:0] PageSize = 64'd1 << PAGE_BITS;
  localparam logic [63:0] PageMask = PageSize - 64'd1;

  state_e      state_q;
  logic        done_q;
  mrts_san_t   res_q;
  logic [63:0] b_q, l_q, e_q, a_q;
  logic [2:0]  kind_q;
  logic        raw_ok_q;

  logic        raw_ok;
  logic [2:0]  kind_dec;
  logic [31:0] raw_m1;
  logic [64:0] sum;
  logic [63:0] low64, cap64, abase, cap_len, len_trim;
  logic        past_cap;

  always_comb begin
    raw_ok   = (raw_kind_i != '0) && (raw_kind_i <= RAW_KIND_MAX);
    raw_m1   = raw_kind_i - 32'd1;
    kind_dec = raw_ok ? raw_m1[2:0] : KIND_INVALID;
    sum      = {1'b0, b_q} + {1'b0, l_q};
    low64    = 64'(low_i);
    cap64    = 64'(cap_i);
    past_cap = e_q > cap64;
    cap_len  = cap64 - b_q;
    len_trim = past_cap ? cap_len : l_q;
    abase    = (b_q + PageMask) & ~PageMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      res_q    <= '0;
      b_q      <= '0;
      l_q      <= '0;
      e_q      <= '0;
      a_q      <= '0;
      kind_q   <= KIND_AVAIL;
      raw_ok_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            b_q      <= base_i;
            l_q      <= len_i;
            kind_q   <= kind_dec;
            raw_ok_q <= raw_ok;
            state_q  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!raw_ok_q) begin
            res_q   <= '{status: ST_BAD_KIND, kind: KIND_INVALID, usable: 1'b0,
                         base: '0, len: '0, end_addr: '0};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (l_q == '0 || sum[64]) begin
            res_q   <= '{status: ST_MALFORMED, kind: kind_q, usable: 1'b0,
                         base: '0, len: '0, end_addr: '0};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (sum[63:0] <= low64) begin
            // wholly below the low limit
            res_q   <= '{status: ST_OK, kind: KIND_RSVD, usable: 1'b0,
                         base: b_q, len: l_q, end_addr: sum[63:0]};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            e_q     <= sum[63:0];
            state_q <= S_CLIP;
          end
        end
        S_CLIP: begin
          if (b_q < low64) begin
            b_q <= low64;
            l_q <= e_q - low64;
          end
          state_q <= S_CAP;
        end
        S_CAP: begin
          if (l_q < PageSize || (past_cap && b_q >= cap64)) begin
            res_q   <= '{status: ST_OK, kind: KIND_RSVD, usable: 1'b0,
                         base: b_q, len: l_q, end_addr: e_q};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            l_q <= len_trim;
            if (past_cap) begin
              e_q <= cap64;
            end
            if (kind_q == KIND_AVAIL) begin
              state_q <= S_ALIGN;
            end else begin
              res_q   <= '{status: ST_OK, kind: kind_q, usable: 1'b0,
                           base: b_q, len: len_trim,
                           end_addr: past_cap ? cap64 : e_q};
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_ALIGN: begin
          a_q     <= abase;
          e_q     <= e_q & ~PageMask;
          state_q <= S_TRIM;
        end
        S_TRIM: begin
          if (a_q >= e_q) begin
            // nothing left after inward alignment
            res_q <= '{status: ST_OK, kind: KIND_RSVD, usable: 1'b0,
                       base: b_q, len: l_q, end_addr: b_q + l_q};
          end else begin
            res_q <= '{status: ST_OK, kind: KIND_AVAIL, usable: 1'b1,
                       base: a_q, len: e_q - a_q, end_addr: e_q};
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- src/memory_region_table_sanitizer.sv -----
// top level: config registers, table ram, overlap scan and result word
module memory_region_table_sanitizer import mrts_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 32,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrts_in_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrts_out_t          out_word_o
);

  // Takes one word at a time. A clear, or an add to a full table, goes straight
  // to the result step and is registered once the output register is free. Any
  // other add runs through the sanitizer's check, clip, cap, align and trim steps,
  // which may end early, and its result then passes through the result step into
  // the output register. A usable region, with N regions stored, first scans the
  // region table, held in one ram with registered read, one stored entry per cycle;
  // a hit ends the scan early. That longest add sets the rate of words. The next
  // word is accepted the cycle after the result is in the output register, even
  // while it still waits there; a result that cannot enter the output register
  // holds the block until the previous one leaves.

  localparam int unsigned AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_REGIONS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_REGIONS);

  typedef enum logic [1:0] {T_IDLE, T_SAN, T_SCAN, T_RESULT} state_e;

  state_e          state_q;
  logic [31:0]     low_q, kbcap_q, total_q, seal_q;
  logic [47:0]     cap_q;
  logic [CntW-1:0] count_q, rd_idx_q;
  logic            op_q, full_q, cmp_vld_q, hit_q, out_valid_q;
  mrts_out_t       out_q, out_d;

  logic            accept, start, full, san_done, ram_re, ram_we, out_free, hit_now;
  mrts_san_t       san;
  logic [127:0]    rdata;
  logic [63:0]     kb_sum;
  logic [31:0]     total_new, seal_new;
  logic [CntW-1:0] count_inc;

  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = count_q >= MaxCnt;
  assign start      = accept && in_word_i.op && !full;
  assign out_free   = !out_valid_q || out_ready_i;

  mrts_sanitize #(.PAGE_BITS(PAGE_BITS)) u_san (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .base_i     (in_word_i.region_base),
    .len_i      (in_word_i.region_length),
    .raw_kind_i (in_word_i.raw_kind),
    .low_i      (low_q),
    .cap_i      (cap_q),
    .done_o     (san_done),
    .res_o      (san)
  );

  always_comb begin
    ram_re    = (state_q == T_SCAN) && (rd_idx_q < count_q);
    hit_now   = cmp_vld_q && (san.base < rdata[63:0]) && (san.end_addr > rdata[127:64]);
    ram_we    = (state_q == T_RESULT) && out_free && op_q && !full_q &&
                (san.status == ST_OK) && !(san.usable && hit_q);
    kb_sum    = 64'(total_q) + (san.len >> KbShift);
    total_new = san.usable ? ((kb_sum > 64'(kbcap_q)) ? kbcap_q : kb_sum[31:0]) : total_q;
    seal_new  = seal_q ^ san.base[31:0] ^ san.len[31:0] ^ 32'(san.kind);
    count_inc = count_q + CntW'(1);
  end

  // result word for the item in its last step
  always_comb begin
    out_d = '0;
    priority if (!op_q) begin
      out_d.status          = ST_OK;
      out_d.map_seal        = SEAL_MAGIC;
    end else if (full_q) begin
      out_d.status          = ST_FULL;
      out_d.entry_count     = 6'(count_q);
      out_d.usable_total_kb = total_q;
      out_d.map_seal        = seal_q;
    end else if (san.status != ST_OK) begin
      out_d.status          = san.status;
      out_d.kind_code       = san.kind;
      out_d.entry_count     = 6'(count_q);
      out_d.usable_total_kb = total_q;
      out_d.map_seal        = seal_q;
    end else if (san.usable && hit_q) begin
      out_d.status          = ST_OVERLAP;
      out_d.kept_base       = san.base;
      out_d.kept_length     = san.len;
      out_d.kind_code       = san.kind;
      out_d.entry_count     = 6'(count_q);
      out_d.usable_total_kb = total_q;
      out_d.map_seal        = seal_q;
    end else begin
      out_d.status          = ST_OK;
      out_d.stored          = 1'b1;
      out_d.usable_flag     = san.usable;
      out_d.kept_base       = san.base;
      out_d.kept_length     = san.len;
      out_d.kind_code       = san.kind;
      out_d.entry_count     = 6'(count_inc);
      out_d.usable_total_kb = total_new;
      out_d.map_seal        = seal_new;
    end
  end

  // table entry holds start and end address of a stored region
  mrts_ram #(.WIDTH(128), .DEPTH(MAX_REGIONS)) u_table (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({san.base, san.end_addr}),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= LOW_LIMIT_RST;
      cap_q   <= UPPER_CAP_RST;
      kbcap_q <= USABLE_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_LIMIT:  low_q   <= cfg_wdata_i[31:0];
        CFG_UPPER_CAP:  cap_q   <= cfg_wdata_i;
        CFG_USABLE_CAP: kbcap_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      seal_q      <= SEAL_MAGIC;
      rd_idx_q    <= '0;
      op_q        <= 1'b0;
      full_q      <= 1'b0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (state_q == T_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            op_q    <= in_word_i.op;
            full_q  <= full;
            hit_q   <= 1'b0;
            state_q <= start ? T_SAN : T_RESULT;
          end
        end
        T_SAN: begin
          if (san_done) begin
            rd_idx_q  <= '0;
            cmp_vld_q <= 1'b0;
            if (san.status == ST_OK && san.usable && count_q != '0) begin
              state_q <= T_SCAN;
            end else begin
              state_q <= T_RESULT;
            end
          end
        end
        T_SCAN: begin
          cmp_vld_q <= ram_re;
          if (ram_re) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          if (hit_now) begin
            hit_q   <= 1'b1;
            state_q <= T_RESULT;
          end else if (!cmp_vld_q && !ram_re) begin
            state_q <= T_RESULT;
          end
        end
        T_RESULT: begin
          if (out_free) begin
            state_q <= T_IDLE;
            out_q   <= out_d;
            if (!op_q) begin
              count_q <= '0;
              total_q <= '0;
              seal_q  <= SEAL_MAGIC;
            end else if (ram_we) begin
              count_q <= count_inc;
              total_q <= total_new;
              seal_q  <= seal_new;
            end
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- tb/tb_memory_region_table_sanitizer.sv -----
// self-checking testbench for the memory region table sanitizer
module tb_memory_region_table_sanitizer;
  import mrts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxRegions = 32;
  localparam int unsigned PageBits = 12;
  localparam int NumDirected = 22;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 210;
  localparam int HoldCycles = 800;
  localparam int HoldAfter = 400;
  localparam int TailCycles = 80;
  // ~1700 words, each with busy time, sender gap and receiver stalls, plus hold-off
  localparam int Limit = 1000000;
  localparam int MaxPrinted = 40;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD = 1'b1;

  localparam logic [31:0] RAW_AVAIL = 32'd1;
  localparam logic [31:0] RAW_RESERVED = 32'd2;
  localparam logic [31:0] RAW_ACPI_RECLAIM = 32'd3;
  localparam logic [31:0] RAW_ACPI_NVS = 32'd4;
  localparam logic [31:0] RAW_BAD_RAM = 32'd5;

  localparam logic [2:0] KIND_ACPI_RECLAIM = 3'd2;
  localparam logic [2:0] KIND_BAD_RAM = 3'd4;

  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    mrts_in_t  word;
    logic      typed;
    mrts_out_t want;
  } feed_t;

  typedef struct packed {
    logic        op;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] kind;
    logic        typed;
    logic [2:0]  st;
    logic [2:0]  kc;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [47:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mrts_in_t           in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mrts_out_t          out_word;

  memory_region_table_sanitizer #(
    .MAX_REGIONS(MaxRegions),
    .PAGE_BITS(PageBits)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o(out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state and its copy of the registers
  logic [63:0] tbl_base [MaxRegions];
  logic [63:0] tbl_len [MaxRegions];
  int unsigned tbl_count = 0;
  logic [31:0] kb_total = '0;
  logic [31:0] seal_acc = SEAL_MAGIC;
  logic [31:0] low_lim = LOW_LIMIT_RST;
  logic [47:0] upper_cap = UPPER_CAP_RST;
  logic [31:0] usable_cap = USABLE_CAP_RST;

  feed_t     region_feed[$];
  mrts_out_t outcome_q[$];

  int errors = 0;
  int cycles = 0;
  int words_in = 0;
  int results_seen = 0;
  int status_tally [5] = '{default: 0};

  // sender and receiver pacing
  int  gap_left = 0;
  int  burst_left = 0;
  bit  took;
  mrts_out_t guess;
  mrts_out_t want_r;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  pat_mode = 0;
  int  pat_left = 0;

  // main sequence temporaries
  dir_row_t  directed_rows [NumDirected];
  mrts_in_t  gen_w;
  mrts_out_t want_w;
  logic [31:0] lo_new;
  logic [31:0] uc_new;
  logic [47:0] cap_new;
  int sel;
  int seq_len;
  int made;
  int phase;

  function automatic bit region_clash(logic [63:0] s, logic [63:0] e);
    for (int i = 0; i < tbl_count && i < MaxRegions; i++) begin
      if (s < tbl_base[i] + tbl_len[i] && e > tbl_base[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mrts_out_t predict_region(mrts_in_t w);
    mrts_out_t   r;
    logic [63:0] b;
    logic [63:0] l;
    logic [63:0] pg;
    logic [63:0] msk;
    logic [63:0] ab;
    logic [63:0] ae;
    logic [63:0] lo;
    logic [63:0] cp;
    logic [63:0] sum;
    logic [2:0]  kc;
    bit          usable;
    bit          rsvd;
    r = '0;
    pg = 64'd1 << PageBits;
    msk = pg - 64'd1;
    lo = 64'(low_lim);
    cp = 64'(upper_cap);
    if (w.op == OP_CLEAR) begin
      tbl_count = 0;
      kb_total = '0;
      seal_acc = SEAL_MAGIC;
      r.status = ST_OK;
    end else if (tbl_count >= MaxRegions) begin
      r.status = ST_FULL;
    end else if (w.raw_kind < RAW_AVAIL || w.raw_kind > RAW_KIND_MAX) begin
      r.status = ST_BAD_KIND;
      r.kind_code = KIND_INVALID;
    end else begin
      kc = 3'(w.raw_kind - RAW_AVAIL);
      b = w.region_base;
      l = w.region_length;
      if (l == 64'd0 || b > ALL_ONES - l) begin
        r.status = ST_MALFORMED;
        r.kind_code = kc;
      end else begin
        rsvd = 1'b0;
        usable = 1'b0;
        if (b + l <= lo) begin
          rsvd = 1'b1;
        end else begin
          if (b < lo) begin
            l = l - (lo - b);
            b = lo;
          end
          if (l < pg) begin
            rsvd = 1'b1;
          end else if (b + l > cp && b >= cp) begin
            rsvd = 1'b1;
          end else begin
            if (b + l > cp) l = cp - b;
            if (kc == KIND_AVAIL) begin
              ab = (b + msk) & ~msk;
              ae = (b + l) & ~msk;
              if (ab >= ae) begin
                rsvd = 1'b1;
              end else begin
                b = ab;
                l = ae - ab;
                usable = 1'b1;
              end
            end
          end
        end
        if (rsvd) kc = KIND_RSVD;
        r.kept_base = b;
        r.kept_length = l;
        r.kind_code = kc;
        if (usable && region_clash(b, b + l)) begin
          r.status = ST_OVERLAP;
        end else begin
          tbl_base[tbl_count] = b;
          tbl_len[tbl_count] = l;
          tbl_count++;
          if (usable) begin
            sum = 64'(kb_total) + (l >> KbShift);
            kb_total = (sum > 64'(usable_cap)) ? usable_cap : sum[31:0];
          end
          seal_acc = seal_acc ^ b[31:0] ^ l[31:0] ^ 32'(kc);
          r.status = ST_OK;
          r.stored = 1'b1;
          r.usable_flag = usable;
        end
      end
    end
    r.entry_count = 6'(tbl_count);
    r.usable_total_kb = kb_total;
    r.map_seal = seal_acc;
    return r;
  endfunction

  task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch %s at result %0d: got %h want %h", what, results_seen, got, want);
    end
  endtask

  task automatic push_item(mrts_in_t w, logic typed, mrts_out_t want);
    feed_t f;
    f.word = w;
    f.typed = typed;
    f.want = want;
    region_feed.push_back(f);
  endtask

  task automatic wait_drained();
    while (region_feed.size() != 0 || outcome_q.size() != 0 || in_valid) @(negedge clk_i);
  endtask

  // sender: bursts of words with random gaps, prediction at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        guess = predict_region(in_word);
        status_tally[guess.status]++;
        outcome_q.push_back(region_feed[0].typed ? region_feed[0].want : guess);
        region_feed.delete(0);
        words_in++;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (region_feed.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= region_feed[0].word;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each word, stalls on its own pattern, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          flag_error("unexpected word status", 64'(out_word.status), 64'd0);
        end else begin
          want_r = outcome_q.pop_front();
          if (out_word.status !== want_r.status)
            flag_error("status", 64'(out_word.status), 64'(want_r.status));
          if (out_word.stored !== want_r.stored)
            flag_error("stored", 64'(out_word.stored), 64'(want_r.stored));
          if (out_word.usable_flag !== want_r.usable_flag)
            flag_error("usable_flag", 64'(out_word.usable_flag), 64'(want_r.usable_flag));
          if (out_word.kept_base !== want_r.kept_base)
            flag_error("kept_base", out_word.kept_base, want_r.kept_base);
          if (out_word.kept_length !== want_r.kept_length)
            flag_error("kept_length", out_word.kept_length, want_r.kept_length);
          if (out_word.kind_code !== want_r.kind_code)
            flag_error("kind_code", 64'(out_word.kind_code), 64'(want_r.kind_code));
          if (out_word.entry_count !== want_r.entry_count)
            flag_error("entry_count", 64'(out_word.entry_count), 64'(want_r.entry_count));
          if (out_word.usable_total_kb !== want_r.usable_total_kb)
            flag_error("usable_total_kb", 64'(out_word.usable_total_kb),
                       64'(want_r.usable_total_kb));
          if (out_word.map_seal !== want_r.map_seal)
            flag_error("map_seal", 64'(out_word.map_seal), 64'(want_r.map_seal));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        // long hold-off so the block backs up into its input
        hold_left = HoldCycles;
        hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat_mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("tb_memory_region_table_sanitizer: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values; typed rows hold for the empty table after reset or clear
    directed_rows = '{
      '{OP_CLEAR, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1'b1, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h10_0000, 64'h1000, 32'd0, 1'b1, ST_BAD_KIND, KIND_INVALID},
      '{OP_ADD, 64'h10_0000, 64'h1000, 32'd6, 1'b1, ST_BAD_KIND, KIND_INVALID},
      '{OP_ADD, 64'h10_0000, 64'h1000, 32'hFFFF_FFFF, 1'b1, ST_BAD_KIND, KIND_INVALID},
      '{OP_ADD, 64'h20_0000, 64'd0, RAW_AVAIL, 1'b1, ST_MALFORMED, KIND_AVAIL},
      '{OP_ADD, ALL_ONES, 64'd1, RAW_ACPI_RECLAIM, 1'b1, ST_MALFORMED, KIND_ACPI_RECLAIM},
      '{OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, RAW_BAD_RAM, 1'b1, ST_MALFORMED,
        KIND_BAD_RAM},
      '{OP_ADD, 64'h0, 64'h1000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'hF_F000, 64'h3000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h10_0800, 64'h2000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h20_0000, 64'hFFF, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h20_0000, 64'h1000, RAW_RESERVED, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h30_0000, 64'h5000, RAW_ACPI_RECLAIM, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h30_0000, 64'h5000, RAW_ACPI_NVS, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h40_0000, 64'h2000, RAW_BAD_RAM, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h1_0000_0000, 64'h1000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'hFFFF_E000, 64'h1_0000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h40_0001, 64'h1000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h50_0000, 64'h8000_0000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h9000_0000, 64'h6000_0000, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL},
      '{OP_CLEAR, 64'h0, 64'h0, 32'h0, 1'b1, ST_OK, KIND_AVAIL},
      '{OP_ADD, 64'h0, ALL_ONES, RAW_AVAIL, 1'b0, ST_OK, KIND_AVAIL}
    };
    foreach (directed_rows[i]) begin
      gen_w.op = directed_rows[i].op;
      gen_w.region_base = directed_rows[i].base;
      gen_w.region_length = directed_rows[i].len;
      gen_w.raw_kind = directed_rows[i].kind;
      want_w = '0;
      want_w.status = directed_rows[i].st;
      want_w.kind_code = directed_rows[i].kc;
      want_w.map_seal = SEAL_MAGIC;
      push_item(gen_w, directed_rows[i].typed, want_w);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          lo_new = '0;
          cap_new = '1;
          uc_new = '1;
        end
        1: begin
          // small usable cap, total carried over from the previous setting
          lo_new = $urandom_range(0, 32'h0100_0000);
          cap_new = 48'(lo_new) + 48'($urandom);
          uc_new = $urandom_range(0, 5000);
        end
        2: begin
          lo_new = '1;
          cap_new = '0;
          uc_new = '0;
        end
        3: begin
          lo_new = LOW_LIMIT_RST;
          cap_new = UPPER_CAP_RST;
          uc_new = USABLE_CAP_RST;
        end
        default: begin
          lo_new = $urandom;
          cap_new = {16'($urandom), 32'($urandom)};
          uc_new = $urandom;
        end
      endcase
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= CFG_LOW_LIMIT;
      cfg_wdata <= 48'(lo_new);
      @(posedge clk_i);
      cfg_idx <= CFG_UPPER_CAP;
      cfg_wdata <= cap_new;
      @(posedge clk_i);
      cfg_idx <= CFG_USABLE_CAP;
      cfg_wdata <= 48'(uc_new);
      @(posedge clk_i);
      cfg_we <= 1'b0;
      low_lim = lo_new;
      upper_cap = cap_new;
      usable_cap = uc_new;
      @(negedge clk_i);

      made = 0;
      while (made < PhaseItems) begin
        // the first run of a setting keeps the table, later runs mostly clear first
        if (made > 0 && $urandom_range(0, 3) != 0) begin
          gen_w.op = OP_CLEAR;
          gen_w.region_base = {$urandom, $urandom};
          gen_w.region_length = {$urandom, $urandom};
          gen_w.raw_kind = $urandom;
          push_item(gen_w, 1'b0, '0);
          made++;
        end
        seq_len = $urandom_range(1, 48);
        repeat (seq_len) begin
          gen_w.op = OP_ADD;
          gen_w.raw_kind = ($urandom_range(0, 9) < 5) ? RAW_AVAIL : 32'($urandom_range(2, 5));
          sel = $urandom_range(0, 99);
          if (sel < 45) begin
            gen_w.region_base = 64'(low_lim) + (64'($urandom_range(0, 127)) << PageBits)
                + (($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : 64'd0);
            gen_w.region_length = (64'($urandom_range(1, 16)) << PageBits)
                + (($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : 64'd0);
          end else if (sel < 58) begin
            // straddles the low limit
            gen_w.region_base = 64'(low_lim) - 64'($urandom_range(0, 32'h4000));
            gen_w.region_length = 64'($urandom_range(1, 32'h8000));
          end else if (sel < 72) begin
            // around the upper cap
            gen_w.region_base = 64'(upper_cap) - 64'($urandom_range(0, 32'h8000));
            gen_w.region_length = 64'($urandom_range(1, 32'h1_0000));
          end else if (sel < 82) begin
            gen_w.region_base = 64'(low_lim) + (64'($urandom_range(0, 127)) << PageBits);
            gen_w.region_length = 64'($urandom_range(0, 32'h1800));
          end else if (sel < 90) begin
            // close to the top of the address space, often wrapping
            gen_w.region_base = ALL_ONES - 64'($urandom_range(0, 32'h1000));
            gen_w.region_length = 64'($urandom_range(0, 32'h2000));
          end else begin
            gen_w.region_base = {$urandom, $urandom};
            gen_w.region_length = {$urandom, $urandom} >> $urandom_range(0, 63);
            gen_w.raw_kind = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 7);
          end
          push_item(gen_w, 1'b0, '0);
          made++;
        end
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (outcome_q.size() != 0) flag_error("words never returned", 64'(outcome_q.size()), 64'd0);
    $display("covered %0d words over %0d register settings: ok %0d, full %0d, bad kind %0d,",
             words_in, NumPhases + 1, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_BAD_KIND]);
    $display("overlap %0d, malformed %0d; one receiver hold-off of %0d cycles, %0d mismatches",
             status_tally[ST_OVERLAP], status_tally[ST_MALFORMED], HoldCycles, errors);
    if (errors == 0) begin
      $display("tb_memory_region_table_sanitizer: clean");
    end else begin
      $display("tb_memory_region_table_sanitizer: errors");
    end
    $finish;
  end

endmodule
